// ===== rtl/two_level_page_table_engine_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-level page table engine
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TLPT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tlpt assertion failed");

// A condition that must never be true outside reset.
`define TLPT_NEVER(label, cond) \
   `TLPT_ASSERT(label, !(cond))

`endif

// ===== rtl/tlpt_pkg.sv =====
// ---------------------------------------------------------------------------
// tlpt_pkg
// Types, widths and codes shared by the page table engine modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpt_pkg;

   localparam int unsigned POOL_TABLES_DEF = 16;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned ENTRY_W     = 32;
   localparam int unsigned CFG_W       = 20;
   localparam int unsigned IDX_W       = 10;
   localparam int unsigned DIR_SLOTS   = 1024;
   localparam int unsigned PAGE_SHIFT  = 12;
   localparam int unsigned DIR_LSB     = 22;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned OPCODE_W    = 2;

   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 64;
   localparam int unsigned RSP_TUSER_W = 3;

   localparam logic [ENTRY_W-1:0] PAGE_FRAME_MASK = 32'hFFFF_F000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MAP    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_UNMAP  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 2'd0,
      ST_DIR_ABSENT     = 2'd1,
      ST_PAGE_ABSENT    = 2'd2,
      ST_POOL_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_OK_INV,
      RES_DIR_ABSENT,
      RES_POOL_EMPTY,
      RES_LOOKUP
   } result_type;

   typedef enum logic {
      DIR_WR_CLEAR,
      DIR_WR_ALLOC
   } dir_wr_sel_type;

   typedef enum logic {
      TBL_WR_DIRECT,
      TBL_WR_SWEEP
   } tbl_wr_sel_type;

   typedef struct packed {
      logic           capture;
      logic           dir_wr_en;
      dir_wr_sel_type dir_wr_sel;
      logic           tbl_wr_en;
      tbl_wr_sel_type tbl_wr_sel;
      logic           tbl_rd_en;
      logic           cnt_inc;
      logic           nft_inc;
      logic           load_rsp;
      result_type     rsp_kind;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       dir_valid;
      logic       pool_full;
      logic       cnt_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== rtl/two_level_page_table_engine_top.sv =====
// ---------------------------------------------------------------------------
// two_level_page_table_engine_top
// Two-level page table engine: map, look up and unmap 4 KiB page entries.
// ---------------------------------------------------------------------------
// After reset the engine clears its 1024-entry directory, one entry per
// cycle, and accepts no request until the clearing is done (the
// configuration port is open throughout). Requests are served one at a
// time. A request is taken, its directory read returns in the next cycle,
// and there, for map, unmap, absent directory and no-op requests, the
// result is formed once the response register is free; a lookup that
// finds a table also waits for the table entry read that follows.
// A map that needs a new table first zeroes it one entry per cycle through
// the table memory's single write port. The result register lets the next
// request be taken while a result still waits on the response side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_page_table_engine_top #(
   parameter int unsigned POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: linear_address [31:0], entry_value [63:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tlpt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: opcode [1:0]
   input  logic [tlpt_pkg::REQ_TUSER_W-1:0] req_tuser,
   // rsp_tdata: physical_address [31:0], invalidate_address [63:32]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tlpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: status [1:0], invalidate [2]
   output logic [tlpt_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // csr_data: pool_base_frame [19:0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlpt_pkg::CFG_W-1:0]       csr_data
);

   tlpt_pkg::cmd_type  cmd;
   tlpt_pkg::stat_type stat;

   // The register accepts a transfer in every cycle.
   assign csr_ready = 1'b1;

   tlpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlpt_datapath #(
      .POOL_TABLES (POOL_TABLES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/tlpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer for the page table engine: directory clearing after reset,
// request evaluation, table allocation sweep and response hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tlpt_pkg::stat_type stat,
   output tlpt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR_DIR,
      S_IDLE,
      S_EVAL,
      S_ALLOC_CLEAR,
      S_ALLOC_DONE,
      S_TBL_EVAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = req_tvalid && req_tready;
      case (state_ff)
         S_CLEAR_DIR: begin
            cmd.dir_wr_en  = 1'b1;
            cmd.dir_wr_sel = tlpt_pkg::DIR_WR_CLEAR;
            cmd.cnt_inc    = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (stat.opcode)
               tlpt_pkg::OP_MAP: begin
                  if (stat.dir_valid) begin
                     if (stat.out_free) begin
                        cmd.tbl_wr_en  = 1'b1;
                        cmd.tbl_wr_sel = tlpt_pkg::TBL_WR_DIRECT;
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_kind   = tlpt_pkg::RES_OK_INV;
                        state_in       = S_IDLE;
                     end
                  end else if (stat.pool_full) begin
                     if (stat.out_free) begin
                        cmd.load_rsp = 1'b1;
                        cmd.rsp_kind = tlpt_pkg::RES_POOL_EMPTY;
                        state_in     = S_IDLE;
                     end
                  end else begin
                     cmd.dir_wr_en  = 1'b1;
                     cmd.dir_wr_sel = tlpt_pkg::DIR_WR_ALLOC;
                     cmd.nft_inc    = 1'b1;
                     state_in       = S_ALLOC_CLEAR;
                  end
               end
               tlpt_pkg::OP_LOOKUP: begin
                  if (stat.dir_valid) begin
                     cmd.tbl_rd_en = 1'b1;
                     state_in      = S_TBL_EVAL;
                  end else if (stat.out_free) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = tlpt_pkg::RES_DIR_ABSENT;
                     state_in     = S_IDLE;
                  end
               end
               tlpt_pkg::OP_UNMAP: begin
                  if (stat.out_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                     if (stat.dir_valid) begin
                        cmd.tbl_wr_en  = 1'b1;
                        cmd.tbl_wr_sel = tlpt_pkg::TBL_WR_DIRECT;
                        cmd.rsp_kind   = tlpt_pkg::RES_OK_INV;
                     end else begin
                        cmd.rsp_kind = tlpt_pkg::RES_DIR_ABSENT;
                     end
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = tlpt_pkg::RES_NONE;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_ALLOC_CLEAR: begin
            // The new table is zeroed one entry per cycle; the mapped entry
            // takes the request's word during the same sweep.
            cmd.tbl_wr_en  = 1'b1;
            cmd.tbl_wr_sel = tlpt_pkg::TBL_WR_SWEEP;
            cmd.cnt_inc    = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_ALLOC_DONE;
            end
         end
         S_ALLOC_DONE: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_kind = tlpt_pkg::RES_OK_INV;
               state_in     = S_IDLE;
            end
         end
         S_TBL_EVAL: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_kind = tlpt_pkg::RES_LOOKUP;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR_DIR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/tlpt_datapath.sv =====
// ---------------------------------------------------------------------------
// tlpt_datapath
// Directory and table memories, request capture, pool and sweep counters,
// configuration register and the registered response stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_page_table_engine_top_macros.svh"

module tlpt_datapath #(
   parameter int unsigned POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tlpt_pkg::cmd_type                cmd,
   output tlpt_pkg::stat_type               stat,
   input  logic [tlpt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [tlpt_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             csr_valid,
   input  logic [tlpt_pkg::CFG_W-1:0]       csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tlpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [tlpt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int unsigned TIDX_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int unsigned NFT_W     = $clog2(POOL_TABLES + 1);
   localparam int unsigned TBL_DEPTH = POOL_TABLES * tlpt_pkg::DIR_SLOTS;
   localparam int unsigned TADDR_W   = $clog2(TBL_DEPTH);
   localparam int unsigned AW        = tlpt_pkg::ADDR_W;
   localparam int unsigned EW        = tlpt_pkg::ENTRY_W;
   localparam int unsigned XW        = tlpt_pkg::IDX_W;

   // Directory entry: present bit above the pool table index.
   logic [TIDX_W:0]  dir_mem [tlpt_pkg::DIR_SLOTS];
   logic [EW-1:0]    tbl_mem [TBL_DEPTH];

   tlpt_pkg::opcode_type op_ff;
   logic [AW-1:0]        la_ff;
   logic [EW-1:0]        ev_ff;
   logic [TIDX_W:0]      dir_rd_ff;
   logic [EW-1:0]        tbl_rd_ff;
   logic [XW-1:0]        cnt_ff;
   logic [XW-1:0]        cnt_in;
   logic [NFT_W-1:0]     nft_ff;
   logic [NFT_W-1:0]     nft_in;
   logic [tlpt_pkg::CFG_W-1:0] cfg_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [tlpt_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [tlpt_pkg::RSP_TUSER_W-1:0] rsp_user_ff;

   logic [XW-1:0]      req_dir_idx;
   logic [XW-1:0]      la_dir_idx;
   logic [XW-1:0]      la_tbl_idx;
   logic [XW-1:0]      dir_waddr;
   logic [TIDX_W:0]    dir_wdata;
   logic [TIDX_W-1:0]  cur_tidx;
   logic [TADDR_W-1:0] tbl_addr_direct;
   logic [TADDR_W-1:0] tbl_waddr;
   logic [EW-1:0]      tbl_wdata;

   logic [AW-1:0]             pa_out;
   tlpt_pkg::status_type      st_out;
   logic                      inv_out;
   logic [AW-1:0]             ia_out;

   assign req_dir_idx = req_tdata[tlpt_pkg::DIR_LSB +: XW];
   assign la_dir_idx  = la_ff[tlpt_pkg::DIR_LSB +: XW];
   assign la_tbl_idx  = la_ff[tlpt_pkg::PAGE_SHIFT +: XW];
   assign cur_tidx    = dir_rd_ff[TIDX_W-1:0];

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= tlpt_pkg::opcode_type'(req_tuser);
         la_ff <= req_tdata[AW-1:0];
         ev_ff <= req_tdata[AW +: EW];
      end
   end

   // ---------------- directory ----------------
   always_comb begin
      if (cmd.dir_wr_sel == tlpt_pkg::DIR_WR_CLEAR) begin
         dir_waddr = cnt_ff;
         dir_wdata = '0;
      end else begin
         dir_waddr = la_dir_idx;
         dir_wdata = {1'b1, nft_ff[TIDX_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dir_wr_en) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      // A fresh allocation also refreshes the read register so that the
      // sweep addresses the new table.
      if (cmd.capture) begin
         dir_rd_ff <= dir_mem[req_dir_idx];
      end else if (cmd.dir_wr_en && (cmd.dir_wr_sel == tlpt_pkg::DIR_WR_ALLOC)) begin
         dir_rd_ff <= dir_wdata;
      end
   end

   // ---------------- page tables ----------------
   assign tbl_addr_direct = TADDR_W'({cur_tidx, la_tbl_idx});

   always_comb begin
      if (cmd.tbl_wr_sel == tlpt_pkg::TBL_WR_SWEEP) begin
         tbl_waddr = TADDR_W'({cur_tidx, cnt_ff});
         tbl_wdata = (cnt_ff == la_tbl_idx) ? ev_ff : '0;
      end else begin
         tbl_waddr = tbl_addr_direct;
         tbl_wdata = (op_ff == tlpt_pkg::OP_MAP) ? ev_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr_en) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (cmd.tbl_rd_en) begin
         tbl_rd_ff <= tbl_mem[tbl_addr_direct];
      end
   end

   // ---------------- counters and configuration ----------------
   assign cnt_in = cmd.cnt_inc ? cnt_ff + 1'b1 : cnt_ff;
   assign nft_in = cmd.nft_inc ? nft_ff + 1'b1 : nft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         nft_ff <= '0;
         cfg_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         nft_ff <= nft_in;
         // The pool base only locates table pages in physical memory; it
         // does not enter any response field.
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
      end
   end

   // ---------------- response stage ----------------
   always_comb begin
      pa_out  = '0;
      st_out  = tlpt_pkg::ST_OK;
      inv_out = 1'b0;
      ia_out  = '0;
      case (cmd.rsp_kind)
         tlpt_pkg::RES_OK_INV: begin
            inv_out = 1'b1;
            ia_out  = la_ff;
         end
         tlpt_pkg::RES_DIR_ABSENT: begin
            st_out = tlpt_pkg::ST_DIR_ABSENT;
         end
         tlpt_pkg::RES_POOL_EMPTY: begin
            st_out = tlpt_pkg::ST_POOL_EXHAUSTED;
         end
         tlpt_pkg::RES_LOOKUP: begin
            if (tbl_rd_ff[0]) begin
               pa_out = tbl_rd_ff & tlpt_pkg::PAGE_FRAME_MASK;
            end else begin
               st_out = tlpt_pkg::ST_PAGE_ABSENT;
            end
         end
         default: begin
            st_out = tlpt_pkg::ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {ia_out, pa_out};
         rsp_user_ff <= {inv_out, st_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign stat.opcode    = op_ff;
   assign stat.dir_valid = dir_rd_ff[TIDX_W];
   assign stat.pool_full = (nft_ff >= NFT_W'(POOL_TABLES));
   assign stat.cnt_last  = &cnt_ff;
   assign stat.out_free  = ~rsp_valid_ff | rsp_tready;

   // ---------------- assertions ----------------
   `TLPT_ASSERT(a_pool_bound, nft_ff <= NFT_W'(POOL_TABLES))
   `TLPT_ASSERT(a_load_when_free, cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
   `TLPT_NEVER(a_tbl_rd_wr_excl, cmd.tbl_wr_en && cmd.tbl_rd_en)
   `TLPT_ASSERT(a_alloc_counts, (cmd.dir_wr_en && cmd.nft_inc) |=> (nft_ff != $past(nft_ff)))
   `TLPT_NEVER(a_alloc_when_full, cmd.nft_inc && stat.pool_full)

endmodule
